// ===== design/trl_pkg.sv =====
// shared types and constants for the temperature ring logger
package trl_pkg;

    // input word: command code and raw converter sample
    typedef struct packed {
        logic [2:0] opcode;
        logic [9:0] sample;
    } in_word_t;

    // output word: result kind and logged byte
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } out_word_t;

    // log memory control from the sequencer
    typedef struct packed {
        logic clear;
        logic wr_en;
    } mem_cmd_t;

    // command codes
    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_PING   = 3'd1;
    localparam logic [2:0] OP_REPORT = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_TX_RDY = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // configuration register indexes
    localparam logic CFG_CAL_OFFSET = 1'b0;
    localparam logic CFG_CAL_GAIN   = 1'b1;

    // shared unit operations
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;

    // dump stages
    localparam logic [1:0] DUMP_IDLE = 2'd0;
    localparam logic [1:0] DUMP_RUN  = 2'd1;
    localparam logic [1:0] DUMP_END  = 2'd2;

    // calibration rounding constant and shift
    localparam logic [15:0] CAL_ROUND = 16'd512;
    localparam int          CAL_SHIFT = 10;

endpackage

// ===== design/trl_alu.sv =====
// shared 16-bit wrapping add, subtract and multiply unit
module trl_alu (
    input  logic [1:0]  op,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] y
);

    logic [31:0] prod;

    // full product, low half kept
    assign prod = {16'b0, a} * {16'b0, b};

    // operation select
    always_comb
    begin
        case (op)
            trl_pkg::ALU_ADD: y = a + b;
            trl_pkg::ALU_SUB: y = a - b;
            trl_pkg::ALU_MUL: y = prod[15:0];
            default:          y = a;
        endcase
    end

endmodule

// ===== design/trl_log_mem.sv =====
// ring log memory with fill count so unwritten entries read as zero
module trl_log_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trl_pkg::mem_cmd_t cmd,
    input  logic [AW-1:0]     wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [7:0]        rd_data
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    data_reg;
    logic          valid_reg;
    logic          valid_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    // entries 1..fill have been written since clear, all once the ring wrapped
    assign valid_next = (fill_reg == FILL_FULL) ||
                        ((rd_addr != '0) && (FW'(rd_addr) <= fill_reg));

    // fill count follows writes, saturating at the depth
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.wr_en && (fill_reg != FILL_FULL))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    // storage array, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    assign rd_data = valid_reg ? data_reg : 8'd0;

endmodule

// ===== design/temperature_ring_logger.sv =====
// top level: command sequencer, calibration through the shared unit, ring log and dump
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one command word:
//   a raw sample, ping, report request, clear, or transmit-ready event.
//   Output channel (out_valid / out_stall / out_word) carries ping acks,
//   logged bytes during a dump, and the end-of-report marker.
//   cal_offset and cal_gain are written through cfg_write / cfg_index / cfg_data;
//   the user must do so only while the block is idle; the block does not enforce it.
// Timing:
//   One word at a time; in_stall is high while a word is being worked on.
//   Report, clear and idle transmit-ready finish in idle; a ping goes through
//   the emit state. A sample that does not close a group is only accumulated;
//   one that does passes accumulate, four steps of the shared add, subtract and
//   multiply unit, and store. A dump entry makes two registered reads of the log
//   memory port. A result sits in the output register; the sequencer waits only
//   when a new result is ready and the previous one has not been taken.
// Reset:
//   Clears all indexes, the sample group, the dump stage and the log fill count,
//   so the whole log reads as zero right after reset with no clearing pass.
module temperature_ring_logger #(
    parameter int LOG_DEPTH           = 512,
    parameter int SAMPLES_PER_READING = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  trl_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output trl_pkg::out_word_t out_word,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] CNT_LAST  = CW'(SAMPLES_PER_READING - 1);
    localparam logic [15:0]   HALF_CNT  = 16'(SAMPLES_PER_READING / 2);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC   = 4'd1;
    localparam logic [3:0] S_CAL0  = 4'd2;
    localparam logic [3:0] S_CAL1  = 4'd3;
    localparam logic [3:0] S_CAL2  = 4'd4;
    localparam logic [3:0] S_CAL3  = 4'd5;
    localparam logic [3:0] S_STORE = 4'd6;
    localparam logic [3:0] S_RD0   = 4'd7;
    localparam logic [3:0] S_RD1   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [15:0]        offset_reg, offset_next;
    logic [15:0]        gain_reg, gain_next;
    logic [15:0]        sum_reg, sum_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        work_reg, work_next;
    logic [9:0]         sample_reg, sample_next;
    logic [AW-1:0]      wr_idx_reg, wr_idx_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [AW-1:0]      stop_idx_reg, stop_idx_next;
    logic [1:0]         stage_reg, stage_next;
    trl_pkg::out_word_t pend_reg, pend_next;
    trl_pkg::out_word_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_accept;
    logic [1:0]         alu_op;
    logic [15:0]        alu_a, alu_b, alu_y;
    trl_pkg::mem_cmd_t  mem_cmd;
    logic [AW-1:0]      mem_rd_addr;
    logic [7:0]         mem_rd_data;
    logic [AW-1:0]      wr_idx_inc;
    logic [AW-1:0]      rd_idx_dec;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // ring index stepping with wrap
    assign wr_idx_inc = (wr_idx_reg == LAST_ADDR) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_dec = (rd_idx_reg == '0) ? LAST_ADDR : rd_idx_reg - 1'b1;

    // shared arithmetic unit
    trl_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // ring log storage
    trl_log_mem #(
        .DEPTH (LOG_DEPTH),
        .AW    (AW)
    ) u_log_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .wr_addr (wr_idx_inc),
        .wr_data ({2'b00, work_reg[15:trl_pkg::CAL_SHIFT]}),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // shared unit operand select per step
    always_comb
    begin
        alu_op = trl_pkg::ALU_ADD;
        alu_a  = work_reg;
        alu_b  = HALF_CNT;
        case (state_reg)
            S_ACC:
            begin
                alu_a = sum_reg;
                alu_b = {6'b0, sample_reg};
            end
            S_CAL0:
            begin
                alu_b = HALF_CNT;
            end
            S_CAL1:
            begin
                alu_op = trl_pkg::ALU_SUB;
                alu_b  = offset_reg;
            end
            S_CAL2:
            begin
                alu_op = trl_pkg::ALU_MUL;
                alu_b  = gain_reg;
            end
            S_CAL3:
            begin
                alu_b = trl_pkg::CAL_ROUND;
            end
            default:
            begin
                alu_b = HALF_CNT;
            end
        endcase
    end

    // log read address: second read of a dump step looks one entry back
    assign mem_rd_addr = (state_reg == S_RD0) ? rd_idx_dec : rd_idx_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        gain_next      = gain_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        work_next      = work_reg;
        sample_next    = sample_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        stop_idx_next  = stop_idx_reg;
        stage_next     = stage_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_cmd.clear  = 1'b0;
        mem_cmd.wr_en  = 1'b0;

        // output register drains when taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_write)
        begin
            if (cfg_index == trl_pkg::CFG_CAL_OFFSET)
            begin
                offset_next = cfg_data;
            end
            else
            begin
                gain_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_word.opcode)
                        trl_pkg::OP_SAMPLE:
                        begin
                            sample_next = in_word.sample;
                            state_next  = S_ACC;
                        end
                        trl_pkg::OP_PING:
                        begin
                            pend_next.kind  = trl_pkg::KIND_ACK;
                            pend_next.value = 8'd0;
                            state_next      = S_EMIT;
                        end
                        trl_pkg::OP_REPORT:
                        begin
                            rd_idx_next   = wr_idx_reg;
                            stop_idx_next = wr_idx_reg;
                            stage_next    = trl_pkg::DUMP_RUN;
                        end
                        trl_pkg::OP_CLEAR:
                        begin
                            mem_cmd.clear = 1'b1;
                            wr_idx_next   = '0;
                        end
                        trl_pkg::OP_TX_RDY:
                        begin
                            if (stage_reg == trl_pkg::DUMP_RUN)
                            begin
                                state_next = S_RD0;
                            end
                            else if (stage_reg == trl_pkg::DUMP_END)
                            begin
                                pend_next.kind  = trl_pkg::KIND_END;
                                pend_next.value = 8'd0;
                                stage_next      = trl_pkg::DUMP_IDLE;
                                state_next      = S_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                if (count_reg == CNT_LAST)
                begin
                    work_next  = alu_y;
                    sum_next   = 16'd0;
                    count_next = '0;
                    state_next = S_CAL0;
                end
                else
                begin
                    sum_next   = alu_y;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CAL0:
            begin
                work_next  = alu_y;
                state_next = S_CAL1;
            end
            S_CAL1:
            begin
                work_next  = alu_y;
                state_next = S_CAL2;
            end
            S_CAL2:
            begin
                work_next  = alu_y;
                state_next = S_CAL3;
            end
            S_CAL3:
            begin
                work_next  = alu_y;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                mem_cmd.wr_en = 1'b1;
                wr_idx_next   = wr_idx_inc;
                state_next    = S_IDLE;
            end
            S_RD0:
            begin
                // entry at the read index is the word to send
                pend_next.kind  = trl_pkg::KIND_ENTRY;
                pend_next.value = mem_rd_data;
                rd_idx_next     = rd_idx_dec;
                state_next      = S_RD1;
            end
            S_RD1:
            begin
                // stop on an empty entry or when back at the start
                if ((mem_rd_data == 8'd0) || (rd_idx_reg == stop_idx_reg))
                begin
                    stage_next = trl_pkg::DUMP_END;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offset_reg    <= 16'd0;
            gain_reg      <= 16'd0;
            sum_reg       <= 16'd0;
            count_reg     <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            stop_idx_reg  <= '0;
            stage_reg     <= trl_pkg::DUMP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            gain_reg      <= gain_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            stop_idx_reg  <= stop_idx_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        sample_reg <= sample_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

endmodule
